// ===== src/qslt_pkg.sv =====
// qslt_pkg: shared widths, register codes, reset values and stage types
// for the quad sensor light tracker. No dependencies.

package qslt_pkg;

   localparam int LIGHT_W    = 13;
   localparam int GAIN_W     = 12;
   localparam int PULSE_W    = 12;
   localparam int DZ_W       = 10;
   localparam int PROD_W     = LIGHT_W + GAIN_W;     // one scaled reading
   localparam int DIFF_W     = PROD_W + 3;           // signed sum difference plus rounding
   localparam int STEP_W     = DIFF_W - 9;           // after dividing by 512
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;
   localparam int QUADS      = 4;

   localparam logic [PULSE_W-1:0] PARK_POSITION = 12'd1300;

   localparam logic [GAIN_W-1:0]  GAIN_TL_RST   = 12'd205;
   localparam logic [GAIN_W-1:0]  GAIN_TR_RST   = 12'd269;
   localparam logic [GAIN_W-1:0]  GAIN_BL_RST   = 12'd269;
   localparam logic [GAIN_W-1:0]  GAIN_BR_RST   = 12'd282;
   localparam logic [PULSE_W-1:0] PULSE_MIN_RST = 12'd500;
   localparam logic [PULSE_W-1:0] PULSE_MAXH_RST = 12'd2100;
   localparam logic [PULSE_W-1:0] PULSE_MAXV_RST = 12'd1400;
   localparam logic [DZ_W-1:0]    DEAD_ZONE_RST = 10'd5;

   // quadrant slots
   localparam int Q_TL = 0;
   localparam int Q_TR = 1;
   localparam int Q_BL = 2;
   localparam int Q_BR = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_TL    = 3'd0,
      CSR_GAIN_TR    = 3'd1,
      CSR_GAIN_BL    = 3'd2,
      CSR_GAIN_BR    = 3'd3,
      CSR_PULSE_MIN  = 3'd4,
      CSR_PULSE_MAXH = 3'd5,
      CSR_PULSE_MAXV = 3'd6,
      CSR_DEAD_ZONE  = 3'd7
   } csr_index_type;

   typedef logic [QUADS-1:0][LIGHT_W-1:0] light_quad_type;
   typedef logic [QUADS-1:0][GAIN_W-1:0]  gain_quad_type;
   typedef logic [QUADS-1:0][PROD_W-1:0]  prod_quad_type;

   typedef struct packed {
      logic signed [STEP_W-1:0] az_step;
      logic signed [STEP_W-1:0] el_step;
      logic                     az_move;
      logic                     el_move;
   } step_type;

endpackage

// ===== src/qslt_scale.sv =====
// qslt_scale: applies the Q4.8 gain to each of the four light readings.
// Depends on qslt_pkg.

module qslt_scale
   import qslt_pkg::*;
(
   input  light_quad_type light,
   input  gain_quad_type  gain,
   output prod_quad_type  prod
);

   always_comb begin
      for (int q = 0; q < QUADS; q++) begin
         prod[q] = PROD_W'(light[q]) * PROD_W'(gain[q]);
      end
   end

endmodule

// ===== src/qslt_step.sv =====
// qslt_step: forms the azimuth and elevation steps from scaled readings,
// rounds half up then truncates toward zero, and applies the dead zone.
// Depends on qslt_pkg.

module qslt_step
   import qslt_pkg::*;
(
   input  prod_quad_type   prod,
   input  logic [DZ_W-1:0] dead_zone,
   output step_type        step
);

   logic [PROD_W:0]          sum_right, sum_left, sum_bottom, sum_top;
   logic signed [DIFF_W-1:0] az_diff, el_diff;
   logic [STEP_W-1:0]        az_mag, el_mag;

   // (d + 256) / 512 truncated toward zero
   function automatic logic signed [STEP_W-1:0] half_step(input logic signed [DIFF_W-1:0] d);
      logic signed [DIFF_W-1:0] biased;
      logic signed [DIFF_W-1:0] adj;
      biased = d + DIFF_W'(256);
      adj    = biased + (biased[DIFF_W-1] ? DIFF_W'(511) : DIFF_W'(0));
      half_step = STEP_W'(adj >>> 9);
   endfunction

   assign sum_right  = {1'b0, prod[Q_TR]} + {1'b0, prod[Q_BR]};
   assign sum_left   = {1'b0, prod[Q_TL]} + {1'b0, prod[Q_BL]};
   assign sum_bottom = {1'b0, prod[Q_BL]} + {1'b0, prod[Q_BR]};
   assign sum_top    = {1'b0, prod[Q_TL]} + {1'b0, prod[Q_TR]};

   assign az_diff = $signed({2'b00, sum_right}) - $signed({2'b00, sum_left});
   assign el_diff = $signed({2'b00, sum_bottom}) - $signed({2'b00, sum_top});

   always_comb begin
      step.az_step = half_step(az_diff);
      step.el_step = half_step(el_diff);
      az_mag = step.az_step[STEP_W-1] ? STEP_W'(-step.az_step) : STEP_W'(step.az_step);
      el_mag = step.el_step[STEP_W-1] ? STEP_W'(-step.el_step) : STEP_W'(step.el_step);
      step.az_move = az_mag > STEP_W'(dead_zone);
      step.el_move = el_mag > STEP_W'(dead_zone);
   end

endmodule

// ===== src/qslt_axis.sv =====
// qslt_axis: position accumulate and limit clamp for one servo axis.
// Depends on qslt_pkg.

module qslt_axis
   import qslt_pkg::*;
(
   input  logic [PULSE_W-1:0]       position,
   input  logic signed [STEP_W-1:0] step,
   input  logic                     move,
   input  logic                     any_move,
   input  logic [PULSE_W-1:0]       limit_lo,
   input  logic [PULSE_W-1:0]       limit_hi,
   output logic [PULSE_W-1:0]       position_next,
   output logic                     drive
);

   localparam int SUM_W = STEP_W + 1;

   logic signed [SUM_W-1:0] sum;

   assign sum = $signed(SUM_W'(position)) + (move ? SUM_W'(step) : SUM_W'(0));

   always_comb begin
      position_next = position;
      drive         = 1'b0;
      if (any_move) begin
         // lower limit checked first, so it wins if inverted limits both fail
         if (sum < $signed(SUM_W'(limit_lo))) begin
            position_next = limit_lo;
         end else if (sum > $signed(SUM_W'(limit_hi))) begin
            position_next = limit_hi;
         end else begin
            position_next = sum[PULSE_W-1:0];
            drive         = 1'b1;
         end
      end
   end

endmodule

// ===== src/quad_sensor_light_tracker.sv =====
// quad_sensor_light_tracker: top level with csr bank, three pipeline stages
// and the two axis position registers. Depends on qslt_pkg, qslt_scale,
// qslt_step and qslt_axis.
//
//   channel | direction | handshake          | payload
//   req_    | in        | req_valid/req_stall | four 13-bit light readings
//   rsp_    | out       | rsp_valid/rsp_stall | two 12-bit pulses, drives, hold
//   csr_    | in        | csr_write           | csr_index, 12-bit csr_data
//
// One item per cycle sustained while rsp_stall is low. After the req transfer, the
// input, product, step and result registers load in turn; rsp_valid marks the last.
// The position loop closes inside the last stage: one add and compare per axis.
// Each stage moves whenever the stage after it is empty or moving, so an item
// is taken while a finished result still waits under rsp_stall.
// Synchronous reset parks both axes at 1300 us and loads the default csrs.

module quad_sensor_light_tracker
   import qslt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [LIGHT_W-1:0]    req_light_top_left,
   input  logic [LIGHT_W-1:0]    req_light_top_right,
   input  logic [LIGHT_W-1:0]    req_light_bottom_left,
   input  logic [LIGHT_W-1:0]    req_light_bottom_right,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [PULSE_W-1:0]    rsp_azimuth_pulse,
   output logic [PULSE_W-1:0]    rsp_elevation_pulse,
   output logic                  rsp_azimuth_drive,
   output logic                  rsp_elevation_drive,
   output logic                  rsp_hold,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // configuration
   gain_quad_type      gain_ff;
   logic [PULSE_W-1:0] pulse_min_ff, pulse_maxh_ff, pulse_maxv_ff;
   logic [DZ_W-1:0]    dead_zone_ff;

   // pipeline
   logic               s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   light_quad_type     light_ff;
   prod_quad_type      prod_in, prod_ff;
   step_type           step_in, step_ff;
   logic               ld1, ld2, ld3, ld_rsp;

   // axis state and results
   logic [PULSE_W-1:0] az_pos_ff, el_pos_ff, az_pos_in, el_pos_in;
   logic               az_drive_in, el_drive_in, any_move;
   logic [PULSE_W-1:0] rsp_az_pulse_ff, rsp_el_pulse_ff;
   logic               rsp_az_drive_ff, rsp_el_drive_ff, rsp_hold_ff;

   assign ld_rsp    = !rsp_valid_ff || !rsp_stall;
   assign ld3       = !s3_valid_ff || ld_rsp;
   assign ld2       = !s2_valid_ff || ld3;
   assign ld1       = !s1_valid_ff || ld2;
   assign req_stall = !ld1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff[Q_TL] <= GAIN_TL_RST;
         gain_ff[Q_TR] <= GAIN_TR_RST;
         gain_ff[Q_BL] <= GAIN_BL_RST;
         gain_ff[Q_BR] <= GAIN_BR_RST;
         pulse_min_ff  <= PULSE_MIN_RST;
         pulse_maxh_ff <= PULSE_MAXH_RST;
         pulse_maxv_ff <= PULSE_MAXV_RST;
         dead_zone_ff  <= DEAD_ZONE_RST;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_GAIN_TL:    gain_ff[Q_TL] <= csr_data;
            CSR_GAIN_TR:    gain_ff[Q_TR] <= csr_data;
            CSR_GAIN_BL:    gain_ff[Q_BL] <= csr_data;
            CSR_GAIN_BR:    gain_ff[Q_BR] <= csr_data;
            CSR_PULSE_MIN:  pulse_min_ff  <= csr_data;
            CSR_PULSE_MAXH: pulse_maxh_ff <= csr_data;
            CSR_PULSE_MAXV: pulse_maxv_ff <= csr_data;
            CSR_DEAD_ZONE:  dead_zone_ff  <= csr_data[DZ_W-1:0];
            default:        dead_zone_ff  <= dead_zone_ff;
         endcase
      end
   end

   qslt_scale u_scale (
      .light (light_ff),
      .gain  (gain_ff),
      .prod  (prod_in)
   );

   qslt_step u_step (
      .prod      (prod_ff),
      .dead_zone (dead_zone_ff),
      .step      (step_in)
   );

   assign any_move = step_ff.az_move || step_ff.el_move;

   qslt_axis u_axis_az (
      .position      (az_pos_ff),
      .step          (step_ff.az_step),
      .move          (step_ff.az_move),
      .any_move      (any_move),
      .limit_lo      (pulse_min_ff),
      .limit_hi      (pulse_maxh_ff),
      .position_next (az_pos_in),
      .drive         (az_drive_in)
   );

   qslt_axis u_axis_el (
      .position      (el_pos_ff),
      .step          (step_ff.el_step),
      .move          (step_ff.el_move),
      .any_move      (any_move),
      .limit_lo      (pulse_min_ff),
      .limit_hi      (pulse_maxv_ff),
      .position_next (el_pos_in),
      .drive         (el_drive_in)
   );

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         az_pos_ff    <= PARK_POSITION;
         el_pos_ff    <= PARK_POSITION;
      end else begin
         if (ld1)    s1_valid_ff  <= req_valid;
         if (ld2)    s2_valid_ff  <= s1_valid_ff;
         if (ld3)    s3_valid_ff  <= s2_valid_ff;
         if (ld_rsp) rsp_valid_ff <= s3_valid_ff;
         if (ld_rsp && s3_valid_ff) begin
            az_pos_ff <= az_pos_in;
            el_pos_ff <= el_pos_in;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (ld1 && req_valid) begin
         light_ff[Q_TL] <= req_light_top_left;
         light_ff[Q_TR] <= req_light_top_right;
         light_ff[Q_BL] <= req_light_bottom_left;
         light_ff[Q_BR] <= req_light_bottom_right;
      end
      if (ld2 && s1_valid_ff) prod_ff <= prod_in;
      if (ld3 && s2_valid_ff) step_ff <= step_in;
      if (ld_rsp && s3_valid_ff) begin
         rsp_az_pulse_ff <= az_pos_in;
         rsp_el_pulse_ff <= el_pos_in;
         rsp_az_drive_ff <= az_drive_in;
         rsp_el_drive_ff <= el_drive_in;
         rsp_hold_ff     <= !any_move;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_azimuth_pulse   = rsp_az_pulse_ff;
   assign rsp_elevation_pulse = rsp_el_pulse_ff;
   assign rsp_azimuth_drive   = rsp_az_drive_ff;
   assign rsp_elevation_drive = rsp_el_drive_ff;
   assign rsp_hold            = rsp_hold_ff;

   // a held result never strobes a servo
   a_hold_no_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_hold_ff |-> !rsp_az_drive_ff && !rsp_el_drive_ff)
      else $error("drive strobe raised on a hold result");

   // a hold transfer leaves both positions where they were
   a_hold_keeps_pos: assert property (@(posedge clock) disable iff (reset)
      ld_rsp && s3_valid_ff && !any_move |=> $stable(az_pos_ff) && $stable(el_pos_ff))
      else $error("position changed without a move");

   // the result register matches the position state written with it
   a_result_tracks_pos: assert property (@(posedge clock) disable iff (reset)
      ld_rsp && s3_valid_ff |=> rsp_az_pulse_ff == az_pos_ff && rsp_el_pulse_ff == el_pos_ff)
      else $error("result pulse differs from stored position");

   // input stalls only when every stage holds an item
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && s2_valid_ff && s3_valid_ff && rsp_valid_ff)
      else $error("input stalled with a free stage");

endmodule

// ===== bench/quad_sensor_light_tracker_tb.sv =====
// quad_sensor_light_tracker_tb: self-checking bench with a directed sweep, then random light
// samples under several csr settings, scored by an in-bench tracker model or a typed row.
// Depends on qslt_pkg and quad_sensor_light_tracker.

module quad_sensor_light_tracker_tb;
   import qslt_pkg::*;

   localparam int CSR_COUNT    = 8;
   localparam int LIMIT_CYCLES = 200000;
   localparam int IDLE_PCT     = 19;

   typedef struct packed {
      logic [PULSE_W-1:0] azimuth_pulse;
      logic [PULSE_W-1:0] elevation_pulse;
      logic               azimuth_drive;
      logic               elevation_drive;
      logic               hold;
   } pointing_type;

   typedef struct packed {
      logic [LIGHT_W-1:0] tl;
      logic [LIGHT_W-1:0] tr;
      logic [LIGHT_W-1:0] bl;
      logic [LIGHT_W-1:0] br;
      logic               typed;
      pointing_type       want;
   } sweep_row_type;

   typedef logic [0:CSR_COUNT-1][CSR_DATA_W-1:0] csr_bank_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [LIGHT_W-1:0]    req_light_top_left = '0;
   logic [LIGHT_W-1:0]    req_light_top_right = '0;
   logic [LIGHT_W-1:0]    req_light_bottom_left = '0;
   logic [LIGHT_W-1:0]    req_light_bottom_right = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [PULSE_W-1:0]    rsp_azimuth_pulse;
   logic [PULSE_W-1:0]    rsp_elevation_pulse;
   logic                  rsp_azimuth_drive;
   logic                  rsp_elevation_drive;
   logic                  rsp_hold;
   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // tracker model state
   logic [CSR_DATA_W-1:0] csr_shadow [CSR_COUNT];
   logic [PULSE_W-1:0]    tracker_az;
   logic [PULSE_W-1:0]    tracker_el;

   pointing_type pending_pointing [$];
   int        send_idle_pct = IDLE_PCT;
   int        rsp_stall_pct = IDLE_PCT;
   int        mismatch_count = 0;
   int        results_checked = 0;
   int        held_count = 0;
   int        both_driven_count = 0;
   int        samples_sent = 0;
   int        cycle_count = 0;

   quad_sensor_light_tracker dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_light_top_left     (req_light_top_left),
      .req_light_top_right    (req_light_top_right),
      .req_light_bottom_left  (req_light_bottom_left),
      .req_light_bottom_right (req_light_bottom_right),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_azimuth_pulse      (rsp_azimuth_pulse),
      .rsp_elevation_pulse    (rsp_elevation_pulse),
      .rsp_azimuth_drive      (rsp_azimuth_drive),
      .rsp_elevation_drive    (rsp_elevation_drive),
      .rsp_hold               (rsp_hold),
      .csr_write              (csr_write),
      .csr_index              (csr_index),
      .csr_data               (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("%0t: timeout with %0d results outstanding", $time, pending_pointing.size());
         $display("quad_sensor_light_tracker verification failed");
         $finish;
      end
   end

   // lower limit wins over the upper one, drive only when already inside
   function automatic logic [PULSE_W-1:0] limit_axis(input longint pos, input longint lo,
                                                     input longint hi, output logic drive);
      drive = 1'b0;
      if (pos < lo) return lo[PULSE_W-1:0];
      if (pos > hi) return hi[PULSE_W-1:0];
      drive = 1'b1;
      return pos[PULSE_W-1:0];
   endfunction

   function automatic pointing_type advance_tracker(input light_quad_type l);
      longint       s_tl, s_tr, s_bl, s_br;
      longint       az_step, el_step, az_pos, el_pos, dz;
      logic         moved;
      logic         az_drive, el_drive;
      pointing_type p;
      s_tl = longint'(l[Q_TL]) * longint'(csr_shadow[CSR_GAIN_TL]);
      s_tr = longint'(l[Q_TR]) * longint'(csr_shadow[CSR_GAIN_TR]);
      s_bl = longint'(l[Q_BL]) * longint'(csr_shadow[CSR_GAIN_BL]);
      s_br = longint'(l[Q_BR]) * longint'(csr_shadow[CSR_GAIN_BR]);
      // add a half in 1/256 mV units, then divide truncating toward zero
      az_step = ((s_tr + s_br) - (s_tl + s_bl) + 256) / 512;
      el_step = ((s_bl + s_br) - (s_tl + s_tr) + 256) / 512;
      az_pos = longint'(tracker_az);
      el_pos = longint'(tracker_el);
      dz = longint'(csr_shadow[CSR_DEAD_ZONE]);
      moved = 1'b0;
      az_drive = 1'b0;
      el_drive = 1'b0;
      if ((az_step < 0 ? -az_step : az_step) > dz) begin
         az_pos += az_step;
         moved = 1'b1;
      end
      if ((el_step < 0 ? -el_step : el_step) > dz) begin
         el_pos += el_step;
         moved = 1'b1;
      end
      if (moved) begin
         tracker_az = limit_axis(az_pos, longint'(csr_shadow[CSR_PULSE_MIN]),
                                 longint'(csr_shadow[CSR_PULSE_MAXH]), az_drive);
         tracker_el = limit_axis(el_pos, longint'(csr_shadow[CSR_PULSE_MIN]),
                                 longint'(csr_shadow[CSR_PULSE_MAXV]), el_drive);
      end
      p.azimuth_pulse = tracker_az;
      p.elevation_pulse = tracker_el;
      p.azimuth_drive = az_drive;
      p.elevation_drive = el_drive;
      p.hold = ~moved;
      return p;
   endfunction

   function automatic light_quad_type pick_lights();
      light_quad_type l;
      int             shape, base, spread, v;
      shape = $urandom_range(0, 99);
      base = int'($urandom_range(0, 6144) >> $urandom_range(0, 9));
      spread = 1 << $urandom_range(0, 7);
      for (int q = 0; q < QUADS; q++) begin
         if (shape < 65) begin
            // near-balanced quad, keeps steps close to the dead zone
            v = base + int'($urandom_range(0, 2 * spread)) - spread;
            if (v < 0) v = 0;
         end else if (shape < 85) begin
            v = int'($urandom_range(0, 8191));
         end else if (shape < 93) begin
            v = int'($urandom_range(0, 6144));
         end else begin
            case ($urandom_range(0, 3))
               0: v = 0;
               1: v = 8191;
               2: v = 6144;
               default: v = 1 << $urandom_range(0, LIGHT_W - 1);
            endcase
         end
         l[q] = v[LIGHT_W-1:0];
      end
      return l;
   endfunction

   function automatic csr_bank_type pick_bank();
      csr_bank_type b;
      int           lo;
      for (int g = CSR_GAIN_TL; g <= CSR_GAIN_BR; g++) begin
         b[g] = ($urandom_range(0, 1) == 1) ? CSR_DATA_W'($urandom_range(200, 320))
                                            : CSR_DATA_W'($urandom_range(0, 4095));
      end
      lo = int'($urandom_range(0, 1500));
      b[CSR_PULSE_MIN] = lo[CSR_DATA_W-1:0];
      b[CSR_PULSE_MAXH] = ($urandom_range(0, 9) == 0) ? CSR_DATA_W'($urandom_range(0, 4095))
                                                      : CSR_DATA_W'($urandom_range(lo, 4095));
      b[CSR_PULSE_MAXV] = ($urandom_range(0, 9) == 0) ? CSR_DATA_W'($urandom_range(0, 4095))
                                                      : CSR_DATA_W'($urandom_range(lo, 4095));
      b[CSR_DEAD_ZONE] = CSR_DATA_W'($urandom_range(0, 1 << $urandom_range(0, 11)));
      return b;
   endfunction

   task automatic program_csrs(input csr_bank_type bank);
      for (int r = 0; r < CSR_COUNT; r++) begin
         csr_write <= 1'b1;
         csr_index <= csr_index_type'(r);
         csr_data <= bank[r];
         if (csr_index_type'(r) == CSR_DEAD_ZONE) begin
            csr_shadow[r] = {{(CSR_DATA_W - DZ_W){1'b0}}, bank[r][DZ_W-1:0]};
         end else begin
            csr_shadow[r] = bank[r];
         end
         @(posedge clock);
      end
      csr_write <= 1'b0;
   endtask

   // returns at the edge of the transfer; a typed row overrides the model's answer
   task automatic offer_lights(input light_quad_type l, input logic typed,
                               input pointing_type want);
      pointing_type p;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_light_top_left <= l[Q_TL];
      req_light_top_right <= l[Q_TR];
      req_light_bottom_left <= l[Q_BL];
      req_light_bottom_right <= l[Q_BR];
      do @(posedge clock); while (req_stall);
      p = advance_tracker(l);
      pending_pointing.push_back(typed ? want : p);
      samples_sent++;
   endtask

   task automatic await_all_results();
      req_valid <= 1'b0;
      while (pending_pointing.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin : rsp_monitor
      pointing_type got;
      pointing_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_azimuth_pulse, rsp_elevation_pulse, rsp_azimuth_drive,
                 rsp_elevation_drive, rsp_hold};
         if (pending_pointing.size() == 0) begin
            $display("%0t: unexpected transfer az %0d el %0d drive %b%b hold %b", $time,
                     got.azimuth_pulse, got.elevation_pulse, got.azimuth_drive,
                     got.elevation_drive, got.hold);
            mismatch_count++;
         end else begin
            want = pending_pointing.pop_front();
            results_checked++;
            if (got.azimuth_pulse !== want.azimuth_pulse) begin
               $display("%0t: azimuth_pulse expected %0d actual %0d", $time,
                        want.azimuth_pulse, got.azimuth_pulse);
               mismatch_count++;
            end
            if (got.elevation_pulse !== want.elevation_pulse) begin
               $display("%0t: elevation_pulse expected %0d actual %0d", $time,
                        want.elevation_pulse, got.elevation_pulse);
               mismatch_count++;
            end
            if (got.azimuth_drive !== want.azimuth_drive) begin
               $display("%0t: azimuth_drive expected %b actual %b", $time,
                        want.azimuth_drive, got.azimuth_drive);
               mismatch_count++;
            end
            if (got.elevation_drive !== want.elevation_drive) begin
               $display("%0t: elevation_drive expected %b actual %b", $time,
                        want.elevation_drive, got.elevation_drive);
               mismatch_count++;
            end
            if (got.hold !== want.hold) begin
               $display("%0t: hold expected %b actual %b", $time, want.hold, got.hold);
               mismatch_count++;
            end
            if (want.hold) held_count++;
            if (want.azimuth_drive && want.elevation_drive) both_driven_count++;
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
   end

   // reset gains 205/269/269/282, limits 500..2100 and 500..1400, dead zone 5
   sweep_row_type sweep_rows [22] = '{
      '{13'd0,    13'd0,    13'd0,    13'd0,    1'b1, '{12'd1300, 12'd1300, 1'b0, 1'b0, 1'b1}},
      '{13'd8191, 13'd8191, 13'd8191, 13'd8191, 1'b1, '{12'd2100, 12'd1400, 1'b0, 1'b0, 1'b0}},
      '{13'd0,    13'd0,    13'd0,    13'd0,    1'b1, '{12'd2100, 12'd1400, 1'b0, 1'b0, 1'b1}},
      '{13'd8191, 13'd0,    13'd0,    13'd0,    1'b1, '{12'd500,  12'd500,  1'b0, 1'b0, 1'b0}},
      '{13'd0,    13'd0,    13'd0,    13'd0,    1'b1, '{12'd500,  12'd500,  1'b0, 1'b0, 1'b1}},
      // step of exactly the dead zone does not move
      '{13'd0,    13'd9,    13'd0,    13'd0,    1'b1, '{12'd500,  12'd500,  1'b0, 1'b0, 1'b1}},
      // azimuth moves, idle elevation is still strobed
      '{13'd0,    13'd11,   13'd0,    13'd0,    1'b1, '{12'd506,  12'd500,  1'b1, 1'b1, 1'b0}},
      '{13'd0,    13'd10,   13'd0,    13'd0,    1'b1, '{12'd506,  12'd500,  1'b0, 1'b0, 1'b1}},
      '{13'd0,    13'd0,    13'd11,   13'd0,    1'b1, '{12'd506,  12'd506,  1'b1, 1'b1, 1'b0}},
      // negative steps truncate toward zero
      '{13'd16,   13'd0,    13'd0,    13'd0,    1'b1, '{12'd506,  12'd506,  1'b0, 1'b0, 1'b1}},
      '{13'd17,   13'd0,    13'd0,    13'd0,    1'b1, '{12'd500,  12'd500,  1'b1, 1'b1, 1'b0}},
      '{13'd17,   13'd0,    13'd0,    13'd0,    1'b1, '{12'd500,  12'd500,  1'b0, 1'b0, 1'b0}},
      '{13'd0,    13'd0,    13'd0,    13'd8191, 1'b0, '0},
      '{13'd0,    13'd8191, 13'd0,    13'd0,    1'b0, '0},
      '{13'd0,    13'd0,    13'd8191, 13'd0,    1'b0, '0},
      '{13'd6144, 13'd6144, 13'd6144, 13'd6144, 1'b0, '0},
      '{13'd6145, 13'd6144, 13'd6143, 13'd6144, 1'b0, '0},
      '{13'h1555, 13'h0aaa, 13'h1555, 13'h0aaa, 1'b0, '0},
      '{13'h0aaa, 13'h1555, 13'h0aaa, 13'h1555, 1'b0, '0},
      '{13'd8191, 13'd8191, 13'd0,    13'd0,    1'b0, '0},
      '{13'd0,    13'd0,    13'd8191, 13'd8191, 1'b0, '0},
      '{13'd1,    13'd1,    13'd1,    13'd1,    1'b0, '0}
   };

   csr_bank_type fixed_banks [5] = '{
      '{12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd0,    12'd4095, 12'd4095, 12'd0},
      '{12'd0,    12'd0,    12'd0,    12'd0,    12'd500,  12'd2100, 12'd1400, 12'd5},
      '{12'd256,  12'd256,  12'd256,  12'd256,  12'd3000, 12'd1000, 12'd0,    12'd3},
      '{12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd0,    12'd4095, 12'd4095, 12'hfff},
      '{12'd300,  12'd250,  12'd280,  12'd260,  12'd4095, 12'd4095, 12'd4095, 12'd1}
   };

   int phase_items [9] = '{200, 60, 200, 200, 100, 210, 210, 210, 210};

   initial begin : stimulus
      light_quad_type l;
      csr_bank_type   bank;
      int             directed_count;
      csr_shadow[CSR_GAIN_TL] = GAIN_TL_RST;
      csr_shadow[CSR_GAIN_TR] = GAIN_TR_RST;
      csr_shadow[CSR_GAIN_BL] = GAIN_BL_RST;
      csr_shadow[CSR_GAIN_BR] = GAIN_BR_RST;
      csr_shadow[CSR_PULSE_MIN] = PULSE_MIN_RST;
      csr_shadow[CSR_PULSE_MAXH] = PULSE_MAXH_RST;
      csr_shadow[CSR_PULSE_MAXV] = PULSE_MAXV_RST;
      csr_shadow[CSR_DEAD_ZONE] = {{(CSR_DATA_W - DZ_W){1'b0}}, DEAD_ZONE_RST};
      tracker_az = PARK_POSITION;
      tracker_el = PARK_POSITION;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (sweep_rows[i]) begin
         l[Q_TL] = sweep_rows[i].tl;
         l[Q_TR] = sweep_rows[i].tr;
         l[Q_BL] = sweep_rows[i].bl;
         l[Q_BR] = sweep_rows[i].br;
         offer_lights(l, sweep_rows[i].typed, sweep_rows[i].want);
      end
      directed_count = samples_sent;

      for (int ph = 0; ph < 9; ph++) begin
         await_all_results();
         bank = (ph < 5) ? fixed_banks[ph] : pick_bank();
         program_csrs(bank);
         // first phase runs with no idling on either side
         send_idle_pct = (ph == 0) ? 0 : IDLE_PCT;
         rsp_stall_pct = (ph == 0) ? 0 : IDLE_PCT;
         for (int n = 0; n < phase_items[ph]; n++) begin
            if (n == phase_items[ph] / 2) await_all_results();
            offer_lights(pick_lights(), 1'b0, '0);
         end
      end

      await_all_results();
      repeat (8) @(posedge clock);
      $display("covered %0d directed and %0d random light samples over 10 csr settings",
               directed_count, samples_sent - directed_count);
      $display("%0d results checked: %0d held, %0d with both axes driven",
               results_checked, held_count, both_driven_count);
      if (mismatch_count == 0) begin
         $display("quad_sensor_light_tracker verification clean");
      end else begin
         $display("quad_sensor_light_tracker verification failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/qslt_pkg.sv
src/qslt_scale.sv
src/qslt_step.sv
src/qslt_axis.sv
src/quad_sensor_light_tracker.sv
bench/quad_sensor_light_tracker_tb.sv
